/* hw/rtl/crc8fr_pkg.sv */
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, constants and the CRC-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

   // Payload bytes kept per frame and expected length of a sensor frame (1..255)
   localparam int unsigned SENSOR_PAYLOAD_LEN = 6;
   localparam int unsigned STORE_IDX_W =
      (SENSOR_PAYLOAD_LEN > 1) ? $clog2(SENSOR_PAYLOAD_LEN) : 1;

   localparam int unsigned NUM_PAYLOAD_OUT = 6;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned CSR_INDEX_W     = 1;

   localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
   localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SENSOR_CMD_RST  = 8'h01;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_BYTE = 1'b0,
      CSR_SENSOR_CMD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_OTHER   = 2'd2
   } frame_status_type;

   typedef struct packed {
      logic [1:0]                             status;
      logic [BYTE_W-1:0]                      command;
      logic [BYTE_W-1:0]                      length;
      logic [NUM_PAYLOAD_OUT-1:0][BYTE_W-1:0] payload;
   } frame_result_type;

   // Running CRC-8, polynomial 0x07, MSB first
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/crc8fr_req_if.sv */
// ----------------------------------------------------------------------------
// crc8fr_req_if
// Byte input channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc8fr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/crc8fr_rsp_if.sv */
// ----------------------------------------------------------------------------
// crc8fr_rsp_if
// Frame result channel: valid/ready handshake with status, header and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc8fr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic [7:0] frame_command;
   logic [7:0] frame_length;
   logic [7:0] payload_0;
   logic [7:0] payload_1;
   logic [7:0] payload_2;
   logic [7:0] payload_3;
   logic [7:0] payload_4;
   logic [7:0] payload_5;

   modport source (output valid, output frame_status, output frame_command,
                   output frame_length, output payload_0, output payload_1,
                   output payload_2, output payload_3, output payload_4,
                   output payload_5, input ready);
   modport sink   (input valid, input frame_status, input frame_command,
                   input frame_length, input payload_0, input payload_1,
                   input payload_2, input payload_3, input payload_4,
                   input payload_5, output ready);
endinterface

`default_nettype wire

/* hw/rtl/crc8fr_core.sv */
// ----------------------------------------------------------------------------
// crc8fr_core
// Frame parser state machine, running CRC-8 and payload store.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire logic [7:0]                     rx_byte,
   input  wire logic [7:0]                     start_byte,
   input  wire logic [7:0]                     sensor_command,
   output logic                                at_check,
   output logic                                emit,
   output crc8fr_pkg::frame_result_type        result
);
   import crc8fr_pkg::*;

   typedef enum logic [4:0] {
      PH_SOF   = 5'b00001,
      PH_CMD   = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CHECK = 5'b10000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] store_ff [SENSOR_PAYLOAD_LEN];
   logic              store_we;
   logic              status_ok;
   logic [1:0]        status;

   assign at_check = (phase_ff == PH_CHECK);
   assign store_we = step && (phase_ff == PH_DATA) &&
                     (count_ff < BYTE_W'(SENSOR_PAYLOAD_LEN));

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      emit     = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_CMD: begin
               cmd_in   = rx_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = rx_byte;
               count_in = '0;
               crc_in   = '0;
               // empty payload goes straight to the check byte
               phase_in = (rx_byte == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               crc_in   = crc8_update(crc_ff, rx_byte);
               count_in = count_ff + 8'd1;
               if (count_in >= len_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               emit     = 1'b1;
               phase_in = PH_SOF;
            end
            default: begin
               phase_in = (rx_byte == start_byte) ? PH_CMD : PH_SOF;
            end
         endcase
      end
   end

   always_comb begin
      status_ok = (cmd_ff == sensor_command) &&
                  (len_ff == BYTE_W'(SENSOR_PAYLOAD_LEN));
      if (rx_byte != crc_ff) begin
         status = STATUS_CRC_ERR;
      end else if (status_ok) begin
         status = STATUS_OK;
      end else begin
         status = STATUS_OTHER;
      end
   end

   assign result.status  = status;
   assign result.command = cmd_ff;
   assign result.length  = len_ff;

   for (genvar j = 0; j < NUM_PAYLOAD_OUT; j++) begin : g_payload
      if (j < SENSOR_PAYLOAD_LEN) begin : g_kept
         assign result.payload[j] = (status == STATUS_OK) ? store_ff[j] : '0;
      end else begin : g_none
         assign result.payload[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOF;
         cmd_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         crc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[STORE_IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/crc8_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// Start-byte / command / length / payload / CRC-8 frame receiver.
//
//   channel | dir | contents
//   --------+-----+-----------------------------------------------
//   req_bus | in  | one received byte per transfer
//   rsp_bus | out | frame status, command, length, six payload bytes
//   csr_*   | in  | write-only: start byte, sensor command
//
// One byte per cycle. Each byte is parsed at its transfer; a check byte
// loads the output register, which holds the result until its transfer.
// Header and payload bytes are taken even while a result waits; only a check
// byte waits for the output register to drain. Reset is synchronous and
// returns the parser to start-byte hunting with the CSRs at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   crc8fr_req_if.sink                           req_bus,
   crc8fr_rsp_if.source                         rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [crc8fr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [crc8fr_pkg::BYTE_W-1:0]   csr_wdata
);
   import crc8fr_pkg::*;

   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] sensor_cmd_ff;
   logic              step;
   logic              at_check;
   logic              emit;
   frame_result_type  result;
   logic              rsp_valid_ff, rsp_valid_in;
   frame_result_type  rsp_data_ff;

   assign req_bus.ready = !at_check || !rsp_valid_ff || rsp_bus.ready;
   assign step          = req_bus.valid && req_bus.ready;

   crc8fr_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .rx_byte        (req_bus.rx_byte),
      .start_byte     (start_byte_ff),
      .sensor_command (sensor_cmd_ff),
      .at_check       (at_check),
      .emit           (emit),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RST;
         sensor_cmd_ff <= SENSOR_CMD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wdata;
            CSR_SENSOR_CMD: sensor_cmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.frame_status  = rsp_data_ff.status;
   assign rsp_bus.frame_command = rsp_data_ff.command;
   assign rsp_bus.frame_length  = rsp_data_ff.length;
   assign rsp_bus.payload_0     = rsp_data_ff.payload[0];
   assign rsp_bus.payload_1     = rsp_data_ff.payload[1];
   assign rsp_bus.payload_2     = rsp_data_ff.payload[2];
   assign rsp_bus.payload_3     = rsp_data_ff.payload[3];
   assign rsp_bus.payload_4     = rsp_data_ff.payload[4];
   assign rsp_bus.payload_5     = rsp_data_ff.payload[5];

endmodule

`default_nettype wire
